FILE: src/ble_adv_data_record_parser_top_assert.svh
// Assertion macros for the advertising data record parser.
`ifndef BLE_ADV_DATA_RECORD_PARSER_TOP_ASSERT_SVH
`define BLE_ADV_DATA_RECORD_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BLEADP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BLEADP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bleadp_pkg.sv
// Types and constants shared by the advertising data record parser.
`timescale 1ns / 1ps

package bleadp_pkg;

  typedef enum logic [1:0] {
    PH_LEN   = 2'd0,
    PH_TYPE  = 2'd1,
    PH_VALUE = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    ROLE_LEN     = 4'd0,
    ROLE_TYPE    = 4'd1,
    ROLE_NAME    = 4'd2,
    ROLE_TXPWR   = 4'd3,
    ROLE_APPEAR  = 4'd4,
    ROLE_FLAGS   = 4'd5,
    ROLE_SUUID   = 4'd6,
    ROLE_MFR     = 4'd7,
    ROLE_SDUUID  = 4'd8,
    ROLE_SDDATA  = 4'd9,
    ROLE_IGNORED = 4'd10
  } role_t;

  // AD type codes.
  localparam logic [7:0] AD_FLAGS     = 8'h01;
  localparam logic [7:0] AD_UUID16_A  = 8'h02;
  localparam logic [7:0] AD_UUID16_B  = 8'h03;
  localparam logic [7:0] AD_UUID32_A  = 8'h04;
  localparam logic [7:0] AD_UUID32_B  = 8'h05;
  localparam logic [7:0] AD_UUID128_A = 8'h06;
  localparam logic [7:0] AD_UUID128_B = 8'h07;
  localparam logic [7:0] AD_NAME      = 8'h09;
  localparam logic [7:0] AD_TXPWR     = 8'h0A;
  localparam logic [7:0] AD_SD16      = 8'h16;
  localparam logic [7:0] AD_APPEAR    = 8'h19;
  localparam logic [7:0] AD_SD32      = 8'h20;
  localparam logic [7:0] AD_SD128     = 8'h21;
  localparam logic [7:0] AD_MFR       = 8'hFF;

  // UUID size codes.
  localparam logic [1:0] UUID_NONE = 2'd0;
  localparam logic [1:0] UUID_16   = 2'd1;
  localparam logic [1:0] UUID_32   = 2'd2;
  localparam logic [1:0] UUID_128  = 2'd3;

  // Presence flag bit positions.
  localparam int unsigned PB_APPEAR  = 0;
  localparam int unsigned PB_MFR     = 1;
  localparam int unsigned PB_NAME    = 2;
  localparam int unsigned PB_SVCDATA = 3;
  localparam int unsigned PB_SVCUUID = 4;
  localparam int unsigned PB_TXPWR   = 5;

  localparam int unsigned PRES_W = 6;

  typedef struct packed {
    phase_t              phase;
    logic [7:0]          bytes_left;
    logic [7:0]          value_pos;
    logic [7:0]          value_len;
    logic [7:0]          cur_type;
    logic [PRES_W-1:0]   presence;
  } parse_state_t;

  typedef struct packed {
    logic [7:0]          byte_value;
    role_t               byte_role;
    logic [7:0]          record_type;
    logic [7:0]          value_offset;
    logic [1:0]          uuid_size_code;
    logic                element_last;
    logic                record_last;
    logic                record_truncated;
    logic [PRES_W-1:0]   presence_flags;
  } tag_result_t;

endpackage

FILE: src/bleadp_tag.sv
// Combinational record walker: tags one payload byte and computes the next parse state.
`timescale 1ns / 1ps

module bleadp_tag (
  input  bleadp_pkg::parse_state_t st,
  input  logic [7:0]               pay_byte,
  input  logic                     pay_last,
  output bleadp_pkg::tag_result_t  res,
  output bleadp_pkg::parse_state_t st_nxt
);

  logic [7:0]  len_m1;
  logic [7:0]  left_m1;
  logic [7:0]  list_mask;
  logic [1:0]  list_code;
  logic [7:0]  sd_size;
  logic [1:0]  sd_code;

  assign len_m1  = st.value_len - 8'd1;
  assign left_m1 = st.bytes_left - 8'd1;

  // UUID list geometry: element size minus one, used as a mask since sizes are powers of two.
  always_comb begin
    case (st.cur_type)
      bleadp_pkg::AD_UUID16_A, bleadp_pkg::AD_UUID16_B: begin
        list_mask = 8'd1;
        list_code = bleadp_pkg::UUID_16;
      end
      bleadp_pkg::AD_UUID32_A, bleadp_pkg::AD_UUID32_B: begin
        list_mask = 8'd3;
        list_code = bleadp_pkg::UUID_32;
      end
      default: begin
        list_mask = 8'd15;
        list_code = bleadp_pkg::UUID_128;
      end
    endcase
  end

  // Service data leading UUID size.
  always_comb begin
    case (st.cur_type)
      bleadp_pkg::AD_SD16: begin
        sd_size = 8'd2;
        sd_code = bleadp_pkg::UUID_16;
      end
      bleadp_pkg::AD_SD32: begin
        sd_size = 8'd4;
        sd_code = bleadp_pkg::UUID_32;
      end
      default: begin
        sd_size = 8'd16;
        sd_code = bleadp_pkg::UUID_128;
      end
    endcase
  end

  always_comb begin
    st_nxt = st;
    res.byte_value       = pay_byte;
    res.byte_role        = bleadp_pkg::ROLE_LEN;
    res.record_type      = 8'd0;
    res.value_offset     = 8'd0;
    res.uuid_size_code   = bleadp_pkg::UUID_NONE;
    res.element_last     = 1'b0;
    res.record_last      = 1'b0;
    res.record_truncated = 1'b0;

    case (st.phase)
      bleadp_pkg::PH_TYPE: begin
        res.byte_role     = bleadp_pkg::ROLE_TYPE;
        res.record_type   = pay_byte;
        st_nxt.cur_type   = pay_byte;
        st_nxt.value_pos  = 8'd0;
        st_nxt.bytes_left = st.value_len;
        // Name and manufacturer count as present even with an empty value.
        if (pay_byte == bleadp_pkg::AD_NAME) begin
          st_nxt.presence[bleadp_pkg::PB_NAME] = 1'b1;
        end
        if (pay_byte == bleadp_pkg::AD_MFR) begin
          st_nxt.presence[bleadp_pkg::PB_MFR] = 1'b1;
        end
        if (st.value_len == 8'd0) begin
          res.record_last = 1'b1;
          st_nxt.phase    = bleadp_pkg::PH_LEN;
        end else begin
          st_nxt.phase    = bleadp_pkg::PH_VALUE;
        end
      end

      bleadp_pkg::PH_VALUE: begin
        res.byte_role     = bleadp_pkg::ROLE_IGNORED;
        res.record_type   = st.cur_type;
        res.value_offset  = st.value_pos;
        st_nxt.value_pos  = st.value_pos + 8'd1;
        st_nxt.bytes_left = left_m1;
        if (left_m1 == 8'd0) begin
          res.record_last = 1'b1;
          st_nxt.phase    = bleadp_pkg::PH_LEN;
        end

        case (st.cur_type)
          bleadp_pkg::AD_NAME: begin
            res.byte_role    = bleadp_pkg::ROLE_NAME;
            res.element_last = (st.value_pos == len_m1);
          end
          bleadp_pkg::AD_MFR: begin
            res.byte_role    = bleadp_pkg::ROLE_MFR;
            res.element_last = (st.value_pos == len_m1);
          end
          bleadp_pkg::AD_TXPWR: begin
            if (st.value_pos == 8'd0) begin
              res.byte_role = bleadp_pkg::ROLE_TXPWR;
              st_nxt.presence[bleadp_pkg::PB_TXPWR] = 1'b1;
            end
          end
          bleadp_pkg::AD_FLAGS: begin
            if (st.value_pos == 8'd0) begin
              res.byte_role = bleadp_pkg::ROLE_FLAGS;
            end
          end
          bleadp_pkg::AD_APPEAR: begin
            // A value shorter than two bytes carries no appearance at all.
            if (st.value_len >= 8'd2 && st.value_pos < 8'd2) begin
              res.byte_role    = bleadp_pkg::ROLE_APPEAR;
              res.element_last = (st.value_pos == 8'd1);
              if (st.value_pos == 8'd1) begin
                st_nxt.presence[bleadp_pkg::PB_APPEAR] = 1'b1;
              end
            end
          end
          bleadp_pkg::AD_UUID16_A, bleadp_pkg::AD_UUID16_B,
          bleadp_pkg::AD_UUID32_A, bleadp_pkg::AD_UUID32_B,
          bleadp_pkg::AD_UUID128_A, bleadp_pkg::AD_UUID128_B: begin
            // Only whole UUIDs are tagged; trailing partial bytes stay ignored.
            if (st.value_pos < (st.value_len & ~list_mask)) begin
              res.byte_role      = bleadp_pkg::ROLE_SUUID;
              res.uuid_size_code = list_code;
              res.element_last   = ((st.value_pos & list_mask) == list_mask);
              if ((st.value_pos & list_mask) == list_mask) begin
                st_nxt.presence[bleadp_pkg::PB_SVCUUID] = 1'b1;
              end
            end
          end
          bleadp_pkg::AD_SD16, bleadp_pkg::AD_SD32, bleadp_pkg::AD_SD128: begin
            if (st.value_len >= sd_size) begin
              if (st.value_pos < sd_size) begin
                res.byte_role      = bleadp_pkg::ROLE_SDUUID;
                res.uuid_size_code = sd_code;
                res.element_last   = (st.value_pos == sd_size - 8'd1);
                if (st.value_pos == sd_size - 8'd1) begin
                  st_nxt.presence[bleadp_pkg::PB_SVCDATA] = 1'b1;
                end
              end else begin
                res.byte_role    = bleadp_pkg::ROLE_SDDATA;
                res.element_last = (st.value_pos == len_m1);
              end
            end
          end
          default: begin
            res.byte_role = bleadp_pkg::ROLE_IGNORED;
          end
        endcase
      end

      default: begin
        // Length byte; a zero length is a complete empty record.
        res.byte_role = bleadp_pkg::ROLE_LEN;
        if (pay_byte == 8'd0) begin
          res.record_last = 1'b1;
          st_nxt.phase    = bleadp_pkg::PH_LEN;
        end else begin
          st_nxt.value_len = pay_byte - 8'd1;
          st_nxt.phase     = bleadp_pkg::PH_TYPE;
        end
      end
    endcase

    if (pay_last && st_nxt.phase != bleadp_pkg::PH_LEN) begin
      res.record_truncated = 1'b1;
      res.record_last      = 1'b0;
    end

    res.presence_flags = st_nxt.presence;

    // The end of a payload returns the walker to its start state.
    if (pay_last) begin
      st_nxt.phase      = bleadp_pkg::PH_LEN;
      st_nxt.bytes_left = 8'd0;
      st_nxt.value_pos  = 8'd0;
      st_nxt.value_len  = 8'd0;
      st_nxt.cur_type   = 8'd0;
      st_nxt.presence   = '0;
    end
  end

endmodule

FILE: src/ble_adv_data_record_parser_top.sv
// Top level of the advertising data record parser with its stream ports and output skid stage.
// A byte's result is registered in the result register at the edge that accepts it, or in the skid
// register while the result register is stalled. Throughput: one byte per cycle while the skid register
// is empty; the tagger is a single combinational pass on the parse state. A result register plus a skid
// register keep in_tready high while one result waits. Synchronous reset (rst_n low) makes the parser
// expect a length byte and clears presence; the byte flagged by in_tlast also returns it to that start state.
`timescale 1ns / 1ps

`include "ble_adv_data_record_parser_top_assert.svh"

module ble_adv_data_record_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] payload_byte
  input  logic        in_tlast,   // payload_last
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] byte_value, [15:8] record_type, [23:16] value_offset, [25:24] uuid_size_code,
  // [26] element_last, [27] record_truncated, [33:28] presence_flags, [39:34] zero
  output logic [39:0] out_tdata,
  output logic [3:0]  out_tuser,  // [3:0] byte_role
  output logic        out_tlast   // record_last
);

  // Parse state lives here; the tagger works on it combinationally for each accepted byte.
  bleadp_pkg::parse_state_t state_r;
  bleadp_pkg::parse_state_t state_nxt;
  bleadp_pkg::tag_result_t  tag_res;

  // Result register and skid register. The skid holds a result that arrived while the
  // result register was stalled, so the input side gets one extra slot of slack.
  bleadp_pkg::tag_result_t  out_r;
  bleadp_pkg::tag_result_t  skid_r;
  logic                     out_valid_r;
  logic                     skid_valid_r;

  logic in_xfer;
  logic out_xfer;

  bleadp_tag u_tag (
    .st       (state_r),
    .pay_byte (in_tdata),
    .pay_last (in_tlast),
    .res      (tag_res),
    .st_nxt   (state_nxt)
  );

  assign in_tready = !skid_valid_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: bleadp_pkg::PH_LEN, bytes_left: 8'd0, value_pos: 8'd0,
                   value_len: 8'd0, cur_type: 8'd0, presence: '0};
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  // Output flow control. When the skid is full the input is stalled, so only a pop
  // can happen, and it moves the skid entry forward.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_xfer) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_xfer) begin
      if (out_valid_r && !out_tready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r  <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_xfer) begin
        out_r <= skid_r;
      end
    end else if (in_xfer) begin
      if (out_valid_r && !out_tready) begin
        skid_r <= tag_res;
      end else begin
        out_r  <= tag_res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r.presence_flags, out_r.record_truncated,
                       out_r.element_last, out_r.uuid_size_code, out_r.value_offset,
                       out_r.record_type, out_r.byte_value};
  assign out_tuser  = out_r.byte_role;
  assign out_tlast  = out_r.record_last;

  // The skid only fills behind an occupied result register.
  `BLEADP_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with empty output")

  // The final byte of a payload leaves the walker at its start state.
  `BLEADP_ASSERT_NEXT(a_last_resets, in_xfer && in_tlast,
    state_r.phase == bleadp_pkg::PH_LEN && state_r.presence == '0,
    "parser not back at start after payload end")

  // A truncated record never reports its end.
  `BLEADP_ASSERT_SAME(a_trunc_not_last, out_valid_r && out_r.record_truncated,
    !out_r.record_last, "truncated record marked complete")

  // A UUID size code only accompanies UUID bytes.
  `BLEADP_ASSERT_SAME(a_uuid_code_role,
    out_valid_r && out_r.uuid_size_code != bleadp_pkg::UUID_NONE,
    out_r.byte_role == bleadp_pkg::ROLE_SUUID || out_r.byte_role == bleadp_pkg::ROLE_SDUUID,
    "uuid size code on a non-uuid byte")

endmodule
